// File: hdl/apev2_pkg.sv
// Package with the shared types and constants of the APEv2 tag item parser.
package apev2_pkg;

    localparam logic [31:0] APE_VERSION  = 32'd2000;
    localparam logic [31:0] FOOTER_BYTES = 32'd32;
    localparam logic [31:0] MIN_LEFT     = 32'd10;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_TAG_VERSION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TAG_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITEM_COUNT  = 2'd2;

    typedef enum logic [2:0] {
        CLS_SIZE    = 3'd0,
        CLS_FLAGS   = 3'd1,
        CLS_KEY     = 3'd2,
        CLS_KEY_END = 3'd3,
        CLS_VALUE   = 3'd4,
        CLS_IGNORED = 3'd5
    } byte_class_t;

    typedef enum logic [1:0] {
        ST_RUNNING  = 2'd0,
        ST_FINISHED = 2'd1,
        ST_OVERRUN  = 2'd2,
        ST_REJECTED = 2'd3
    } parse_status_t;

    typedef struct packed {
        logic [31:0] tag_version;
        logic [31:0] tag_length;
        logic [31:0] item_count;
    } cfg_t;

    typedef struct packed {
        byte_class_t   byte_class;
        logic [7:0]    byte_echo;
        logic [31:0]   item_number;
        logic [31:0]   value_size;
        logic [31:0]   item_flags;
        logic          value_last;
        parse_status_t status;
        logic [19:0]   bytes_left;
    } result_t;

endpackage

// File: hdl/apev2_if.sv
// Handshake channel interfaces for tag bytes, parsed results and configuration writes.
interface apev2_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, output data_byte, output first, input ready);
    modport sink (input valid, input data_byte, input first, output ready);
endinterface

interface apev2_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  byte_class;
    logic [7:0]  byte_echo;
    logic [31:0] item_number;
    logic [31:0] value_size;
    logic [31:0] item_flags;
    logic        value_last;
    logic [1:0]  status;
    logic [19:0] bytes_left;

    modport source (output valid, output byte_class, output byte_echo, output item_number,
                    output value_size, output item_flags, output value_last,
                    output status, output bytes_left, input ready);
    modport sink (input valid, input byte_class, input byte_echo, input item_number,
                  input value_size, input item_flags, input value_last,
                  input status, input bytes_left, output ready);
endinterface

interface apev2_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [31:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: hdl/apev2_cfg_regs.sv
// Footer configuration registers written through the configuration channel.
module apev2_cfg_regs
    import apev2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    apev2_cfg_if.sink   cfg,
    output cfg_t        cfg_values
);

    cfg_t cfg_reg;

    assign cfg.ready  = 1'b1;
    assign cfg_values = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tag_version <= APE_VERSION;
            cfg_reg.tag_length  <= '0;
            cfg_reg.item_count  <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_TAG_VERSION: cfg_reg.tag_version <= cfg.data;
                CFG_TAG_LENGTH:  cfg_reg.tag_length  <= cfg.data;
                CFG_ITEM_COUNT:  cfg_reg.item_count  <= cfg.data;
                default:
                begin
                end
            endcase
        end
    end

endmodule

// File: hdl/apev2_parse_core.sv
// Parser state registers and the single-pass logic that classifies one tag byte.
module apev2_parse_core
    import apev2_pkg::*;
#(
    parameter int unsigned MAX_TAG_BYTES = 1048576
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       first,
    input  cfg_t       cfg_values,
    output result_t    result
);

    localparam int unsigned REM_W   = $clog2(MAX_TAG_BYTES + 1);
    localparam logic [31:0] MAX_LEN = 32'(MAX_TAG_BYTES);

    typedef enum logic [2:0] {
        PH_HDR   = 3'd0,
        PH_SIZE  = 3'd1,
        PH_FLAGS = 3'd2,
        PH_KEY   = 3'd3,
        PH_VALUE = 3'd4
    } phase_t;

    logic [REM_W-1:0] remaining_reg, remaining_cur, remaining_next;
    logic [31:0]      items_left_reg, items_left_cur, items_left_next;
    phase_t           phase_reg, phase_cur, phase_next;
    logic [1:0]       pos_reg, pos_cur, pos_next;
    logic [31:0]      size_reg, size_cur, size_next;
    logic [31:0]      flags_reg, flags_cur, flags_next;
    logic [31:0]      value_left_reg, value_left_cur, value_left_next;
    logic [31:0]      item_index_reg, item_index_cur, item_index_next;
    parse_status_t    status_reg, status_cur, status_next;

    logic             reject;
    logic [REM_W-1:0] remaining_dec;
    logic [31:0]      value_left_dec;
    logic             end_item;
    byte_class_t      cls;
    logic             last;

    assign reject = (cfg_values.tag_version != APE_VERSION) ||
                    (cfg_values.tag_length <= (FOOTER_BYTES + MIN_LEFT)) ||
                    (cfg_values.tag_length > MAX_LEN);

    // A first byte restarts the parse from the footer before the byte itself is handled.
    always_comb
    begin
        remaining_cur  = remaining_reg;
        items_left_cur = items_left_reg;
        phase_cur      = phase_reg;
        pos_cur        = pos_reg;
        size_cur       = size_reg;
        flags_cur      = flags_reg;
        value_left_cur = value_left_reg;
        item_index_cur = item_index_reg;
        status_cur     = status_reg;
        if (first)
        begin
            item_index_cur = '0;
            size_cur       = '0;
            flags_cur      = '0;
            pos_cur        = '0;
            value_left_cur = '0;
            phase_cur      = PH_HDR;
            if (reject)
            begin
                status_cur     = ST_REJECTED;
                remaining_cur  = '0;
                items_left_cur = '0;
            end
            else
            begin
                remaining_cur  = REM_W'(cfg_values.tag_length - FOOTER_BYTES);
                items_left_cur = cfg_values.item_count;
                status_cur     = (cfg_values.item_count == '0) ? ST_FINISHED : ST_RUNNING;
            end
        end
    end

    assign remaining_dec  = remaining_cur - REM_W'(1);
    assign value_left_dec = (value_left_cur != '0) ? (value_left_cur - 32'd1) : value_left_cur;

    always_comb
    begin
        remaining_next  = remaining_cur;
        items_left_next = items_left_cur;
        phase_next      = phase_cur;
        pos_next        = pos_cur;
        size_next       = size_cur;
        flags_next      = flags_cur;
        value_left_next = value_left_cur;
        item_index_next = item_index_cur;
        status_next     = status_cur;
        cls             = CLS_IGNORED;
        last            = 1'b0;
        end_item        = 1'b0;

        if (status_cur == ST_RUNNING)
        begin
            if ((phase_cur != PH_HDR) && (remaining_cur == '0))
            begin
                status_next = ST_OVERRUN;
            end
            else
            begin
                unique case (phase_cur)
                    PH_HDR:
                    begin
                        if ((items_left_cur == '0) || (32'(remaining_cur) <= MIN_LEFT))
                        begin
                            status_next = ST_FINISHED;
                        end
                        else
                        begin
                            items_left_next = items_left_cur - 32'd1;
                            size_next       = 32'(data_byte);
                            flags_next      = '0;
                            pos_next        = 2'd1;
                            phase_next      = PH_SIZE;
                            remaining_next  = remaining_dec;
                            cls             = CLS_SIZE;
                        end
                    end
                    PH_SIZE:
                    begin
                        size_next      = size_cur | (32'(data_byte) << {pos_cur, 3'b000});
                        pos_next       = pos_cur + 2'd1;
                        remaining_next = remaining_dec;
                        cls            = CLS_SIZE;
                        if (pos_cur == 2'd3)
                        begin
                            phase_next = PH_FLAGS;
                        end
                    end
                    PH_FLAGS:
                    begin
                        flags_next     = flags_cur | (32'(data_byte) << {pos_cur, 3'b000});
                        pos_next       = pos_cur + 2'd1;
                        remaining_next = remaining_dec;
                        cls            = CLS_FLAGS;
                        if (pos_cur == 2'd3)
                        begin
                            phase_next = PH_KEY;
                        end
                    end
                    PH_KEY:
                    begin
                        remaining_next = remaining_dec;
                        if ((32'(remaining_cur) > size_cur) && (data_byte != 8'd0))
                        begin
                            cls = CLS_KEY;
                        end
                        else
                        begin
                            cls = CLS_KEY_END;
                            if (32'(remaining_dec) < size_cur)
                            begin
                                status_next = ST_OVERRUN;
                            end
                            else if (size_cur == '0)
                            begin
                                last     = 1'b1;
                                end_item = 1'b1;
                            end
                            else
                            begin
                                value_left_next = size_cur;
                                phase_next      = PH_VALUE;
                            end
                        end
                    end
                    PH_VALUE:
                    begin
                        cls             = CLS_VALUE;
                        remaining_next  = remaining_dec;
                        value_left_next = value_left_dec;
                        if (value_left_dec == '0)
                        begin
                            last     = 1'b1;
                            end_item = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end

        if (end_item)
        begin
            item_index_next = item_index_cur + 32'd1;
            phase_next      = PH_HDR;
            if ((items_left_cur == '0) || (32'(remaining_next) <= MIN_LEFT))
            begin
                status_next = ST_FINISHED;
            end
        end
    end

    always_comb
    begin
        result.byte_class  = cls;
        result.byte_echo   = data_byte;
        result.item_number = item_index_cur;
        result.value_size  = size_next;
        result.item_flags  = flags_next;
        result.value_last  = last;
        result.status      = status_next;
        result.bytes_left  = 20'(remaining_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remaining_reg  <= '0;
            items_left_reg <= '0;
            phase_reg      <= PH_HDR;
            pos_reg        <= '0;
            size_reg       <= '0;
            flags_reg      <= '0;
            value_left_reg <= '0;
            item_index_reg <= '0;
            status_reg     <= ST_FINISHED;
        end
        else if (step)
        begin
            remaining_reg  <= remaining_next;
            items_left_reg <= items_left_next;
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            size_reg       <= size_next;
            flags_reg      <= flags_next;
            value_left_reg <= value_left_next;
            item_index_reg <= item_index_next;
            status_reg     <= status_next;
        end
    end

endmodule

// File: hdl/apev2_tag_item_parser_top.sv
// Top level of the APEv2 tag item parser with input and result registers.
// A byte waits in the input register until the parse logic writes its result to the result register.
// Throughput: one byte per cycle unless results stall, set by the single-pass parse logic.
// The input register takes a new byte whenever its current byte moves to the result register.
// Reset clears the handshake state, loads the default footer registers and leaves the parser finished.
module apev2_tag_item_parser_top
    import apev2_pkg::*;
#(
    parameter int unsigned MAX_TAG_BYTES = 1048576
)
(
    input  logic           clk,
    input  logic           rst_n,
    apev2_cfg_if.sink      cfg,
    apev2_byte_if.sink     tag_bytes,
    apev2_result_if.source parsed
);

    cfg_t       cfg_values;
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_first_reg;
    logic       out_valid_reg;
    result_t    out_item_reg;
    result_t    result;
    logic       advance;

    assign advance         = in_valid_reg && (!out_valid_reg || parsed.ready);
    assign tag_bytes.ready = !in_valid_reg || advance;

    apev2_cfg_regs u_cfg_regs
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cfg_values (cfg_values)
    );

    apev2_parse_core #(
        .MAX_TAG_BYTES (MAX_TAG_BYTES)
    ) u_parse_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .data_byte  (in_byte_reg),
        .first      (in_first_reg),
        .cfg_values (cfg_values),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tag_bytes.valid && tag_bytes.ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (parsed.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_bytes.valid && tag_bytes.ready)
        begin
            in_byte_reg  <= tag_bytes.data_byte;
            in_first_reg <= tag_bytes.first;
        end
        if (advance)
        begin
            out_item_reg <= result;
        end
    end

    assign parsed.valid       = out_valid_reg;
    assign parsed.byte_class  = out_item_reg.byte_class;
    assign parsed.byte_echo   = out_item_reg.byte_echo;
    assign parsed.item_number = out_item_reg.item_number;
    assign parsed.value_size  = out_item_reg.value_size;
    assign parsed.item_flags  = out_item_reg.item_flags;
    assign parsed.value_last  = out_item_reg.value_last;
    assign parsed.status      = out_item_reg.status;
    assign parsed.bytes_left  = out_item_reg.bytes_left;

    // A held byte that cannot move on must block the input side.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> !tag_bytes.ready)
        else $error("Input register would be overwritten while still held.");

    // A rejected footer never produces a classified byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_item_reg.status == ST_REJECTED))
            |-> (out_item_reg.byte_class == CLS_IGNORED))
        else $error("Byte classified after the footer was rejected.");

    // The last-value flag only accompanies a key end or a value byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_item_reg.value_last)
            |-> ((out_item_reg.byte_class == CLS_KEY_END) ||
                 (out_item_reg.byte_class == CLS_VALUE)))
        else $error("Last-value flag on a byte outside the value.");

    // Every parse step loads the result register and raises its valid flag.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("Result lost after the parse step.");

endmodule

// File: dv/apev2_tag_item_parser_top_tb.sv
// Self-checking testbench for the APEv2 tag item parser: predicts every parsed byte and checks it.
`timescale 1ns / 100ps

module apev2_tag_item_parser_top_tb;
    import apev2_pkg::*;

    localparam int unsigned MAX_TAG_BYTES = 1048576;
    localparam int unsigned RANDOM_BYTES  = 900;
    localparam int unsigned HOLD_CYCLES   = 200;
    localparam int unsigned MAX_PRINTED   = 100;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SIZE,
        PH_FLAGS,
        PH_KEY,
        PH_VALUE
    } walk_phase_t;

    typedef struct packed {
        logic [7:0] data;
        logic       first;
    } tag_byte_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    apev2_cfg_if    cfg_ch ();
    apev2_byte_if   byte_ch ();
    apev2_result_if result_ch ();

    logic        cfg_valid    = 1'b0;
    logic [1:0]  cfg_index    = CFG_TAG_VERSION;
    logic [31:0] cfg_data     = 32'd0;
    logic        byte_valid   = 1'b0;
    logic [7:0]  byte_data    = 8'd0;
    logic        byte_first   = 1'b0;
    logic        result_ready = 1'b0;
    logic        hold_off     = 1'b0;
    logic        hold_armed   = 1'b0;
    logic        idling_on;

    assign cfg_ch.valid     = cfg_valid;
    assign cfg_ch.index     = cfg_index;
    assign cfg_ch.data      = cfg_data;
    assign byte_ch.valid    = byte_valid;
    assign byte_ch.data_byte = byte_data;
    assign byte_ch.first    = byte_first;
    assign result_ch.ready  = result_ready;

    tag_byte_t   pending_bytes [$];
    result_t     expected_results [$];
    logic [7:0]  tag_body [$];
    int unsigned bytes_outstanding = 0;
    int unsigned bytes_accepted    = 0;
    int unsigned mismatch_count    = 0;

    // Footer registers and parse state as the predictor sees them.
    logic [31:0]   cfg_version;
    logic [31:0]   cfg_length;
    logic [31:0]   cfg_count;
    logic [20:0]   body_left;
    logic [31:0]   items_todo;
    walk_phase_t   phase;
    logic [1:0]    word_pos;
    logic [31:0]   size_acc;
    logic [31:0]   flags_acc;
    logic [31:0]   value_cnt;
    logic [31:0]   item_idx;
    parse_status_t run_status;

    assign idling_on = !(bytes_accepted >= 400 && bytes_accepted < 650);

    apev2_tag_item_parser_top #(
        .MAX_TAG_BYTES(MAX_TAG_BYTES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_ch),
        .tag_bytes (byte_ch),
        .parsed    (result_ch)
    );

    always #5 clk = ~clk;

    function automatic void reset_parser_model();
        cfg_version = APE_VERSION;
        cfg_length  = 32'd0;
        cfg_count   = 32'd0;
        body_left   = '0;
        items_todo  = '0;
        phase       = PH_HEADER;
        word_pos    = '0;
        size_acc    = '0;
        flags_acc   = '0;
        value_cnt   = '0;
        item_idx    = '0;
        run_status  = ST_FINISHED;
    endfunction

    function automatic void close_item();
        item_idx = item_idx + 32'd1;
        phase    = PH_HEADER;
        if (items_todo == 0 || body_left <= MIN_LEFT)
            run_status = ST_FINISHED;
    endfunction

    function automatic result_t parse_byte(input logic [7:0] b, input logic first);
        result_t     r;
        byte_class_t cls;
        logic        last;
        logic [31:0] num;
        cls  = CLS_IGNORED;
        last = 1'b0;
        if (first)
        begin
            item_idx  = '0;
            size_acc  = '0;
            flags_acc = '0;
            word_pos  = '0;
            value_cnt = '0;
            phase     = PH_HEADER;
            if (cfg_version != APE_VERSION || cfg_length <= FOOTER_BYTES + MIN_LEFT
                    || cfg_length > MAX_TAG_BYTES)
            begin
                run_status = ST_REJECTED;
                body_left  = '0;
                items_todo = '0;
            end
            else
            begin
                body_left  = 21'(cfg_length - FOOTER_BYTES);
                items_todo = cfg_count;
                run_status = (cfg_count == 0) ? ST_FINISHED : ST_RUNNING;
            end
        end
        num = item_idx;
        if (run_status == ST_RUNNING)
        begin
            if (phase != PH_HEADER && body_left == 0)
                run_status = ST_OVERRUN;
            else
            begin
                case (phase)
                    PH_HEADER:
                    begin
                        if (items_todo == 0 || body_left <= MIN_LEFT)
                            run_status = ST_FINISHED;
                        else
                        begin
                            items_todo = items_todo - 32'd1;
                            size_acc   = 32'(b);
                            flags_acc  = '0;
                            word_pos   = 2'd1;
                            phase      = PH_SIZE;
                            body_left  = body_left - 21'd1;
                            cls        = CLS_SIZE;
                        end
                    end
                    PH_SIZE:
                    begin
                        size_acc  = size_acc | (32'(b) << (8 * word_pos));
                        word_pos  = word_pos + 2'd1;
                        body_left = body_left - 21'd1;
                        cls       = CLS_SIZE;
                        if (word_pos == 0)
                            phase = PH_FLAGS;
                    end
                    PH_FLAGS:
                    begin
                        flags_acc = flags_acc | (32'(b) << (8 * word_pos));
                        word_pos  = word_pos + 2'd1;
                        body_left = body_left - 21'd1;
                        cls       = CLS_FLAGS;
                        if (word_pos == 0)
                            phase = PH_KEY;
                    end
                    PH_KEY:
                    begin
                        body_left = body_left - 21'd1;
                        if (32'(body_left) + 32'd1 > size_acc && b != 8'd0)
                            cls = CLS_KEY;
                        else
                        begin
                            cls = CLS_KEY_END;
                            if (32'(body_left) < size_acc)
                                run_status = ST_OVERRUN;
                            else if (size_acc == 0)
                            begin
                                last = 1'b1;
                                close_item();
                            end
                            else
                            begin
                                value_cnt = size_acc;
                                phase     = PH_VALUE;
                            end
                        end
                    end
                    default:
                    begin
                        cls       = CLS_VALUE;
                        body_left = body_left - 21'd1;
                        if (value_cnt > 0)
                            value_cnt = value_cnt - 32'd1;
                        if (value_cnt == 0)
                        begin
                            last = 1'b1;
                            close_item();
                        end
                    end
                endcase
            end
        end
        if (cls == CLS_IGNORED)
            num = item_idx;
        r.byte_class  = cls;
        r.byte_echo   = b;
        r.item_number = num;
        r.value_size  = size_acc;
        r.item_flags  = flags_acc;
        r.value_last  = last;
        r.status      = run_status;
        r.bytes_left  = body_left[19:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic void push_word(input logic [31:0] w);
        for (int k = 0; k < 4; k++)
            tag_body.push_back(w[8*k +: 8]);
    endfunction

    task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_TAG_VERSION: cfg_version = value;
            CFG_TAG_LENGTH:  cfg_length  = value;
            CFG_ITEM_COUNT:  cfg_count   = value;
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (bytes_outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_tag(input logic [31:0] version, input logic [31:0] length,
                            input logic [31:0] count, input int restart_at,
                            input bit stall_results);
        tag_byte_t entry;
        write_register(CFG_TAG_VERSION, version);
        write_register(CFG_TAG_LENGTH, length);
        write_register(CFG_ITEM_COUNT, count);
        foreach (tag_body[i])
        begin
            entry.data  = tag_body[i];
            entry.first = (i == 0) || (i == restart_at);
            pending_bytes.push_back(entry);
        end
        bytes_outstanding += tag_body.size();
        if (stall_results)
            hold_armed = 1'b1;
        wait_idle();
    endtask

    task automatic build_random_tag(input bit long_tag, output logic [31:0] version,
                                    output logic [31:0] length, output logic [31:0] count,
                                    output int restart_at);
        int items;
        int value_bytes;
        int pick;
        tag_body.delete();
        restart_at = -1;
        version    = APE_VERSION;
        items      = long_tag ? 10 : $urandom_range(1, 5);
        if (!long_tag && $urandom_range(9) == 0)
        begin
            repeat ($urandom_range(20, 60)) tag_body.push_back(8'($urandom));
            length = FOOTER_BYTES + tag_body.size();
            count  = $urandom_range(1, 4);
        end
        else
        begin
            for (int i = 0; i < items; i++)
            begin
                if (long_tag)
                    value_bytes = $urandom_range(20, 40);
                else if ($urandom_range(7) == 0)
                    value_bytes = $urandom_range(13, 60);
                else
                    value_bytes = $urandom_range(0, 12);
                push_word(value_bytes);
                push_word($urandom);
                repeat ($urandom_range(1, 8)) tag_body.push_back(8'($urandom_range(1, 255)));
                tag_body.push_back(8'h00);
                repeat (value_bytes) tag_body.push_back(8'($urandom));
            end
            while (tag_body.size() < 11)
                tag_body.push_back(8'($urandom));
            length = FOOTER_BYTES + tag_body.size();
            count  = items;
            if (!long_tag)
            begin
                pick = $urandom_range(99);
                if (pick < 15)
                begin
                    repeat ($urandom_range(1, 20)) tag_body.push_back(8'($urandom));
                    length = FOOTER_BYTES + tag_body.size();
                end
                else if (pick < 30)
                    length = length - $urandom_range(1, tag_body.size() / 2);
                else if (pick < 35)
                    length = MAX_TAG_BYTES;
                else if (pick < 40)
                    length = $urandom;
                pick = $urandom_range(99);
                if (pick < 10)
                    count = items + $urandom_range(1, 3);
                else if (pick < 20)
                    count = $urandom_range(1, items);
                else if (pick < 25)
                    count = $urandom;
                if ($urandom_range(99) < 5)
                    version = $urandom;
                if ($urandom_range(9) == 0)
                    restart_at = $urandom_range(1, tag_body.size() - 1);
            end
        end
    endtask

    always @(posedge clk)
    begin : byte_driver
        tag_byte_t next_byte;
        if (!rst_n)
            byte_valid <= 1'b0;
        else
        begin
            if (byte_valid && byte_ch.ready === 1'b1)
            begin
                expected_results.push_back(parse_byte(byte_data, byte_first));
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!byte_valid || byte_ch.ready === 1'b1)
            begin
                if (pending_bytes.size() != 0 && !(idling_on && $urandom_range(99) < 7))
                begin
                    next_byte = pending_bytes.pop_front();
                    byte_valid <= 1'b1;
                    byte_data  <= next_byte.data;
                    byte_first <= next_byte.first;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        result_t want;
        if (rst_n && result_ready && result_ch.valid === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", 32'(result_ch.byte_echo), 32'd0);
            else
            begin
                want = expected_results.pop_front();
                bytes_outstanding--;
                if (result_ch.byte_class !== want.byte_class)
                    report_mismatch("byte_class", 32'(result_ch.byte_class),
                                    32'(want.byte_class));
                if (result_ch.byte_echo !== want.byte_echo)
                    report_mismatch("byte_echo", 32'(result_ch.byte_echo), 32'(want.byte_echo));
                if (result_ch.item_number !== want.item_number)
                    report_mismatch("item_number", result_ch.item_number, want.item_number);
                if (result_ch.value_size !== want.value_size)
                    report_mismatch("value_size", result_ch.value_size, want.value_size);
                if (result_ch.item_flags !== want.item_flags)
                    report_mismatch("item_flags", result_ch.item_flags, want.item_flags);
                if (result_ch.value_last !== want.value_last)
                    report_mismatch("value_last", 32'(result_ch.value_last),
                                    32'(want.value_last));
                if (result_ch.status !== want.status)
                    report_mismatch("status", 32'(result_ch.status), 32'(want.status));
                if (result_ch.bytes_left !== want.bytes_left)
                    report_mismatch("bytes_left", 32'(result_ch.bytes_left),
                                    32'(want.bytes_left));
            end
        end
        result_ready <= !hold_off && !(idling_on && $urandom_range(99) < 7);
    end

    // Holds the result side off for a long stretch while the bytes of a long tag keep coming.
    initial
    begin : result_hold
        wait (hold_armed);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : run_limit
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] version;
        logic [31:0] length;
        logic [31:0] count;
        int          restart_at;
        bit          long_tag;
        int unsigned well_formed_bytes;
        tag_byte_t   loose_byte;

        reset_parser_model();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // A byte before any first item finds the parser finished.
        loose_byte.data  = 8'h5A;
        loose_byte.first = 1'b0;
        pending_bytes.push_back(loose_byte);
        bytes_outstanding++;
        wait_idle();

        // Footers that must be rejected.
        tag_body.delete();
        tag_body.push_back(8'hFF);
        send_tag(32'hFFFF_FFFF, 32'd100, 32'd1, -1, 1'b0);
        tag_body[0] = 8'h00;
        send_tag(32'd0, 32'd0, 32'd1, -1, 1'b0);
        tag_body[0] = 8'h01;
        send_tag(APE_VERSION, FOOTER_BYTES + MIN_LEFT, 32'd1, -1, 1'b0);
        tag_body[0] = 8'h80;
        send_tag(APE_VERSION, MAX_TAG_BYTES + 1, 32'd1, -1, 1'b0);
        tag_body[0] = 8'h7F;
        send_tag(APE_VERSION, 32'hFFFF_FFFF, 32'd1, -1, 1'b0);

        // An accepted footer that announces no items.
        send_tag(APE_VERSION, FOOTER_BYTES + MIN_LEFT + 1, 32'd0, -1, 1'b0);

        // A key without NUL and a zero size runs the body dry.
        tag_body.delete();
        push_word(32'd0);
        push_word(32'hFFFF_FFFF);
        push_word(32'h7E43_4241);
        send_tag(APE_VERSION, FOOTER_BYTES + MIN_LEFT + 1, 32'hFFFF_FFFF, -1, 1'b0);

        // A value size larger than the body left ends the key at once with an overrun.
        tag_body.delete();
        push_word(32'hFFFF_FFFF);
        push_word(32'd0);
        tag_body.push_back(8'h41);
        send_tag(APE_VERSION, 32'd50, 32'd1, -1, 1'b0);

        well_formed_bytes = 0;
        long_tag = 1'b1;
        while (well_formed_bytes < RANDOM_BYTES)
        begin
            build_random_tag(long_tag, version, length, count, restart_at);
            if (version == APE_VERSION && length > FOOTER_BYTES + MIN_LEFT
                    && length <= MAX_TAG_BYTES)
                well_formed_bytes += tag_body.size();
            send_tag(version, length, count, restart_at, long_tag);
            long_tag = 1'b0;
        end

        wait_idle();
        if (expected_results.size() != 0)
            report_mismatch("results never delivered", expected_results.size(), 32'd0);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: files.f
hdl/apev2_pkg.sv
hdl/apev2_if.sv
hdl/apev2_cfg_regs.sv
hdl/apev2_parse_core.sv
hdl/apev2_tag_item_parser_top.sv
dv/apev2_tag_item_parser_top_tb.sv
